[rtl/vrll_pkg.sv]
// Shared types and constants for the lat/long vector rotator.
// Used by vrll_cell, vrll_gain, vrll_rot and vector_rotate_lat_long_top.
`timescale 1ns / 1ps

package vrll_pkg;

  // Datapath width: every component carries 32 bits of scaled magnitude plus growth headroom.
  localparam int IW = 36;
  // Angle width in Q30, wide enough for a full-scale angle field before folding.
  localparam int TW = 35;
  // Split point of the gain multiplication into two partial products.
  localparam int SPLIT = 16;
  // Number of entries in the arctangent table.
  localparam int ATAN_N = 24;

  localparam logic signed [TW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [TW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [30:0]   K_Q30       = 31'sd652032874;

  typedef struct packed {
    logic signed [IW-1:0] a;
    logic signed [IW-1:0] b;
    logic signed [TW-1:0] th;
  } cordic_t;

  typedef struct packed {
    logic signed [IW-1:0] a;
    logic signed [IW-1:0] b;
  } pair_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [TW-1:0] atan_q30(input int unsigned idx);
    logic signed [TW-1:0] v;
    unique case (idx)
      0:       v = 35'sh3243F6A8;
      1:       v = 35'sh1DAC6705;
      2:       v = 35'sh0FADBAFC;
      3:       v = 35'sh07F56EA6;
      4:       v = 35'sh03FEAB76;
      5:       v = 35'sh01FFD55B;
      6:       v = 35'sh00FFFAAA;
      7:       v = 35'sh007FFF55;
      8:       v = 35'sh003FFFEA;
      9:       v = 35'sh001FFFFD;
      10:      v = 35'sh000FFFFF;
      11:      v = 35'sh0007FFFF;
      12:      v = 35'sh0003FFFF;
      13:      v = 35'sh0001FFFF;
      14:      v = 35'sh0000FFFF;
      15:      v = 35'sh00007FFF;
      16:      v = 35'sh00003FFF;
      17:      v = 35'sh00001FFF;
      18:      v = 35'sh00000FFF;
      19:      v = 35'sh000007FF;
      20:      v = 35'sh000003FF;
      21:      v = 35'sh000001FF;
      22:      v = 35'sh000000FF;
      23:      v = 35'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/vrll_cell.sv]
// One CORDIC rotation iteration as a registered pipeline cell.
// Depends on vrll_pkg for the datapath types and the arctangent table.
`timescale 1ns / 1ps

module vrll_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vrll_pkg::cordic_t     in_data,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vrll_pkg::cordic_t     out_data,
  output logic [SIDE_W-1:0]     out_side
);

  localparam logic signed [vrll_pkg::TW-1:0] ATAN = vrll_pkg::atan_q30(STAGE);

  logic                  valid_r;
  vrll_pkg::cordic_t     data_r;
  vrll_pkg::cordic_t     data_nxt;
  logic [SIDE_W-1:0]     side_r;
  logic signed [vrll_pkg::IW-1:0] sa;
  logic signed [vrll_pkg::IW-1:0] sb;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    sa = in_data.a >>> STAGE;
    sb = in_data.b >>> STAGE;
    // rotate towards zero residual angle
    if (!in_data.th[vrll_pkg::TW-1]) begin
      data_nxt.a  = in_data.a - sb;
      data_nxt.b  = in_data.b + sa;
      data_nxt.th = in_data.th - ATAN;
    end else begin
      data_nxt.a  = in_data.a + sb;
      data_nxt.b  = in_data.b - sa;
      data_nxt.th = in_data.th + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_side  = side_r;

endmodule

[rtl/vrll_gain.sv]
// Two-stage gain compensation: split multiply by K, then sum and floor >> 30.
// Depends on vrll_pkg for the pair type and the gain constant.
`timescale 1ns / 1ps

module vrll_gain #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vrll_pkg::pair_t   in_data,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output vrll_pkg::pair_t   out_data,
  output logic [SIDE_W-1:0] out_side
);

  localparam int IW   = vrll_pkg::IW;
  localparam int SP   = vrll_pkg::SPLIT;
  localparam int HW   = IW - SP;
  localparam int PHW  = HW + 31;
  localparam int PLW  = SP + 1 + 31;
  localparam int SUMW = PHW + SP + 1;

  logic                   mul_valid_r;
  logic                   mul_ready;
  logic signed [PHW-1:0]  ah_r, bh_r;
  logic signed [PLW-1:0]  al_r, bl_r;
  logic [SIDE_W-1:0]      mul_side_r;

  logic                   sum_valid_r;
  vrll_pkg::pair_t        sum_r;
  vrll_pkg::pair_t        sum_nxt;
  logic [SIDE_W-1:0]      sum_side_r;

  logic signed [HW-1:0]   a_hi, b_hi;
  logic signed [SP:0]     a_lo, b_lo;
  logic signed [SUMW-1:0] sa, sb;

  assign in_ready  = !mul_valid_r || mul_ready;
  assign mul_ready = !sum_valid_r || out_ready;

  assign a_hi = in_data.a[IW-1:SP];
  assign b_hi = in_data.b[IW-1:SP];
  assign a_lo = {1'b0, in_data.a[SP-1:0]};
  assign b_lo = {1'b0, in_data.b[SP-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (in_ready) begin
      mul_valid_r <= in_valid;
    end
  end

  // widen both operands so the products keep every bit
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ah_r       <= PHW'(a_hi) * PHW'(vrll_pkg::K_Q30);
      bh_r       <= PHW'(b_hi) * PHW'(vrll_pkg::K_Q30);
      al_r       <= PLW'(a_lo) * PLW'(vrll_pkg::K_Q30);
      bl_r       <= PLW'(b_lo) * PLW'(vrll_pkg::K_Q30);
      mul_side_r <= in_side;
    end
  end

  // recombine the partial products; the floor shift keeps only the integer part
  always_comb begin
    sa = (SUMW'(ah_r) <<< SP) + SUMW'(al_r);
    sb = (SUMW'(bh_r) <<< SP) + SUMW'(bl_r);
    sum_nxt.a = sa[30 +: IW];
    sum_nxt.b = sb[30 +: IW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (mul_ready) begin
      sum_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid_r && mul_ready) begin
      sum_r      <= sum_nxt;
      sum_side_r <= mul_side_r;
    end
  end

  assign out_valid = sum_valid_r;
  assign out_data  = sum_r;
  assign out_side  = sum_side_r;

endmodule

[rtl/vrll_rot.sv]
// One plane rotation: quadrant fold, a chain of CORDIC cells, gain compensation.
// Depends on vrll_pkg, vrll_cell and vrll_gain.
`timescale 1ns / 1ps

module vrll_rot #(
  parameter int STAGES = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vrll_pkg::cordic_t in_data,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output vrll_pkg::pair_t   out_data,
  output logic [SIDE_W-1:0] out_side
);

  logic              fold_valid_r;
  vrll_pkg::cordic_t fold_r;
  vrll_pkg::cordic_t fold_nxt;
  logic [SIDE_W-1:0] fold_side_r;

  logic              c_valid [STAGES+1];
  logic              c_ready [STAGES+1];
  vrll_pkg::cordic_t c_data  [STAGES+1];
  logic [SIDE_W-1:0] c_side  [STAGES+1];
  vrll_pkg::pair_t   gain_in;

  // beyond +-pi/2: negate the pair and move the angle by pi
  always_comb begin
    fold_nxt = in_data;
    if (in_data.th > vrll_pkg::HALF_PI_Q30) begin
      fold_nxt.a  = -in_data.a;
      fold_nxt.b  = -in_data.b;
      fold_nxt.th = in_data.th - vrll_pkg::PI_Q30;
    end else if (in_data.th < -vrll_pkg::HALF_PI_Q30) begin
      fold_nxt.a  = -in_data.a;
      fold_nxt.b  = -in_data.b;
      fold_nxt.th = in_data.th + vrll_pkg::PI_Q30;
    end
  end

  assign in_ready = !fold_valid_r || c_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_valid_r <= 1'b0;
    end else if (in_ready) begin
      fold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fold_r      <= fold_nxt;
      fold_side_r <= in_side;
    end
  end

  assign c_valid[0] = fold_valid_r;
  assign c_data[0]  = fold_r;
  assign c_side[0]  = fold_side_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    vrll_cell #(
      .STAGE  (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_data   (c_data[i]),
      .in_side   (c_side[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_data  (c_data[i+1]),
      .out_side  (c_side[i+1])
    );
  end

  assign gain_in.a = c_data[STAGES].a;
  assign gain_in.b = c_data[STAGES].b;

  vrll_gain #(
    .SIDE_W (SIDE_W)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid[STAGES]),
    .in_ready  (c_ready[STAGES]),
    .in_data   (gain_in),
    .in_side   (c_side[STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_side  (out_side)
  );

endmodule

[rtl/vector_rotate_lat_long_top.sv]
// Top level of the lat/long vector rotator: z rotation, then y rotation, then rounding.
// Depends on vrll_pkg and vrll_rot.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_vec_x, in_vec_y, in_vec_z, in_lat/lon_angle
//   out     | output    | out_valid/out_stall | out_rot_x, out_rot_y, out_rot_z
//
// One beat enters per cycle while in_stall is low; the path runs through the two
// chains of CORDIC cells, each with a fold register and a two-stage gain multiplier.
// Reset (rst_n low, synchronous) empties every stage; no clearing pass is needed.
// A stall on out holds the output register; the stall ripples back only as far as the
// first empty stage, so bubbles are squeezed out and in_stall rises only when all are full.
`timescale 1ns / 1ps

module vector_rotate_lat_long_top #(
  parameter int DATA_WIDTH    = 20,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0]  in_vec_x,
  input  logic signed [DATA_WIDTH-1:0]  in_vec_y,
  input  logic signed [DATA_WIDTH-1:0]  in_vec_z,
  input  logic signed [ANGLE_WIDTH-1:0] in_lat_angle,
  input  logic signed [ANGLE_WIDTH-1:0] in_lon_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_rot_x,
  output logic signed [DATA_WIDTH-1:0]  out_rot_y,
  output logic signed [DATA_WIDTH-1:0]  out_rot_z
);

  localparam int IW        = vrll_pkg::IW;
  localparam int TW        = vrll_pkg::TW;
  localparam int GUARD     = 32 - DATA_WIDTH;
  localparam int ANG_SHIFT = 33 - ANGLE_WIDTH;
  localparam int SIDE1_W   = IW + TW;

  localparam logic signed [IW:0] RND    = (IW+1)'((longint'(1) << GUARD) - 1);
  localparam logic signed [IW:0] SAT_HI = (IW+1)'((longint'(1) << (DATA_WIDTH-1)) - 1);
  localparam logic signed [IW:0] SAT_LO = -SAT_HI - 1;

  logic signed [IW-1:0] x_s, y_s, z_s;
  logic signed [TW-1:0] lat_s, lon_s;

  vrll_pkg::cordic_t    r1_in;
  logic                 r1_in_ready;
  logic                 r1_valid;
  logic                 r1_ready;
  vrll_pkg::pair_t      r1_out;
  logic [SIDE1_W-1:0]   r1_side;

  vrll_pkg::cordic_t    r2_in;
  logic                 r2_valid;
  logic                 fin_ready;
  vrll_pkg::pair_t      r2_out;
  logic [IW-1:0]        r2_side;

  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] rot_x_r, rot_y_r, rot_z_r;

  // drop the guard bits toward zero, then clamp to the output range
  function automatic logic signed [DATA_WIDTH-1:0] finish(input logic signed [IW-1:0] v);
    logic signed [IW:0] bias;
    logic signed [IW:0] r;
    logic signed [DATA_WIDTH-1:0] res;
    bias = RND;
    if (!v[IW-1]) begin
      bias = '0;
    end
    r = ((IW+1)'(v) + bias) >>> GUARD;
    if (r > SAT_HI) begin
      res = SAT_HI[DATA_WIDTH-1:0];
    end else if (r < SAT_LO) begin
      res = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      res = r[DATA_WIDTH-1:0];
    end
    return res;
  endfunction

  assign x_s   = IW'(in_vec_x) <<< GUARD;
  assign y_s   = IW'(in_vec_y) <<< GUARD;
  assign z_s   = IW'(in_vec_z) <<< GUARD;
  assign lat_s = TW'(in_lat_angle) <<< ANG_SHIFT;
  assign lon_s = TW'(in_lon_angle) <<< ANG_SHIFT;

  assign r1_in.a  = x_s;
  assign r1_in.b  = y_s;
  assign r1_in.th = lat_s;

  assign in_stall = !r1_in_ready;

  vrll_rot #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SIDE1_W)
  ) u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (r1_in_ready),
    .in_data   (r1_in),
    .in_side   ({z_s, lon_s}),
    .out_valid (r1_valid),
    .out_ready (r1_ready),
    .out_data  (r1_out),
    .out_side  (r1_side)
  );

  // second rotation works on the (z, x') pair; y' rides alongside
  assign r2_in.a  = r1_side[SIDE1_W-1:TW];
  assign r2_in.b  = r1_out.a;
  assign r2_in.th = r1_side[TW-1:0];

  vrll_rot #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (IW)
  ) u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r1_valid),
    .in_ready  (r1_ready),
    .in_data   (r2_in),
    .in_side   (r1_out.b),
    .out_valid (r2_valid),
    .out_ready (fin_ready),
    .out_data  (r2_out),
    .out_side  (r2_side)
  );

  assign fin_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r2_valid && fin_ready) begin
      rot_x_r <= finish(r2_out.b);
      rot_y_r <= finish(signed'(r2_side));
      rot_z_r <= finish(r2_out.a);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rot_x = rot_x_r;
  assign out_rot_y = rot_y_r;
  assign out_rot_z = rot_z_r;

`ifndef ASSERT_OFF
  // an empty output register frees the whole chain
  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // a free output side never backs up to the input
  a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled although the output is not stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat present straight after reset");

  // a beat leaving the last rotator must land in the output register
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (r2_valid && fin_ready) |=> out_valid)
    else $error("finished beat lost at the output register");
`endif

endmodule
